// File: rtl/bth_pkg.sv
// shared types and constants for the block transition histogram
// no dependencies; compiled first
`timescale 1ns / 1ps

package bth_pkg;

  // defaults for the top-level parameters
  localparam int MAX_BLOCK_BITS_DEF = 4;
  localparam int COUNT_WIDTH_DEF    = 16;

  // fixed widths of the channel fields and the size register
  localparam int BLOCK_FIELD_W = 4;
  localparam int COUNT_FIELD_W = 16;
  localparam int SIZE_W        = 3;

  // reset value of the block size register
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

  // operation carried by an input beat
  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  // counter store request issued by the assembler
  typedef struct packed {
    logic valid;
    logic is_read;
  } mem_req_t;

endpackage

// File: rtl/bth_in_if.sv
// input channel of the block transition histogram: valid/ready plus payload
// depends on bth_pkg
`timescale 1ns / 1ps

interface bth_in_if;
  import bth_pkg::*;

  logic                     valid;
  logic                     ready;
  func_t                    func;
  logic                     cell_bit;
  logic [BLOCK_FIELD_W-1:0] from_block;
  logic [BLOCK_FIELD_W-1:0] to_block;

  modport source (output valid, func, cell_bit, from_block, to_block, input ready);
  modport sink   (input valid, func, cell_bit, from_block, to_block, output ready);
endinterface

// File: rtl/bth_out_if.sv
// result channel of the block transition histogram: valid/ready plus payload
// depends on bth_pkg
`timescale 1ns / 1ps

interface bth_out_if;
  import bth_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COUNT_FIELD_W-1:0] count;
  logic                     is_saturated;

  modport source (output valid, count, is_saturated, input ready);
  modport sink   (input valid, count, is_saturated, output ready);
endinterface

// File: rtl/bth_assembler.sv
// packs pushed cell bits into blocks, tracks the previous block and
// issues counter store requests; depends on bth_pkg
`timescale 1ns / 1ps

module bth_assembler #(
  parameter int MAX_BLOCK_BITS = bth_pkg::MAX_BLOCK_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bth_pkg::SIZE_W-1:0]        cfg_wr_data,
  input  logic                              accept,
  input  bth_pkg::func_t                    func,
  input  logic                              cell_bit,
  input  logic [bth_pkg::BLOCK_FIELD_W-1:0] from_block,
  input  logic [bth_pkg::BLOCK_FIELD_W-1:0] to_block,
  output bth_pkg::mem_req_t                 req,
  output logic [2*MAX_BLOCK_BITS-1:0]       req_addr
);
  import bth_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK_BITS + 1);
  localparam logic [CNT_W-1:0] MAX_SIZE = CNT_W'(MAX_BLOCK_BITS);

  logic [SIZE_W-1:0]         size_r;
  logic [MAX_BLOCK_BITS-1:0] asm_r, asm_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [MAX_BLOCK_BITS-1:0] prev_r, prev_nxt;
  logic                      have_prev_r, have_prev_nxt;

  logic [CNT_W-1:0]          eff_size;
  logic [CNT_W-1:0]          cnt_inc;
  logic [MAX_BLOCK_BITS-1:0] asm_shift;
  logic                      block_done;

  // clamp the configured size into 1..MAX_BLOCK_BITS
  always_comb begin
    if (size_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (32'(size_r) > MAX_BLOCK_BITS) begin
      eff_size = MAX_SIZE;
    end else begin
      eff_size = CNT_W'(size_r);
    end
  end

  // shift the new bit in at the lsb, first bit ends up as the msb of the block
  assign asm_shift  = MAX_BLOCK_BITS'({asm_r, cell_bit});
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign block_done = (cnt_inc >= eff_size);

  // next assembly state and store request
  always_comb begin
    asm_nxt       = asm_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    req.valid     = 1'b0;
    req.is_read   = 1'b0;
    req_addr      = {MAX_BLOCK_BITS'(from_block), MAX_BLOCK_BITS'(to_block)};
    if (accept) begin
      unique case (func)
        FUNC_READ: begin
          req.valid   = 1'b1;
          req.is_read = 1'b1;
        end
        FUNC_PUSH: begin
          if (block_done) begin
            req.valid     = have_prev_r;
            req_addr      = {prev_r, asm_shift};
            prev_nxt      = asm_shift;
            have_prev_nxt = 1'b1;
            asm_nxt       = '0;
            cnt_nxt       = '0;
          end else begin
            asm_nxt = asm_shift;
            cnt_nxt = cnt_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // state registers; a size write drops the partial block and the history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      asm_r       <= '0;
      cnt_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (cfg_wr_en) begin
      size_r      <= cfg_wr_data;
      asm_r       <= '0;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
    end else begin
      asm_r       <= asm_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  // partial block never holds a full block
  a_cnt_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < eff_size)
    else $error("partial bit count reached block size");

  // an increment only follows a completed previous block
  a_inc_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && !req.is_read) |-> have_prev_r)
    else $error("increment issued without a previous block");

  // effective size always lands in 1..MAX_BLOCK_BITS
  a_size_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (eff_size != '0) && (eff_size <= MAX_SIZE))
    else $error("effective block size out of range");

endmodule

// File: rtl/bth_count_mem.sv
// transition counter store: clearing pass, read-modify-write stage with
// forwarding, and the result register; depends on bth_pkg
`timescale 1ns / 1ps

module bth_count_mem #(
  parameter int MAX_BLOCK_BITS = bth_pkg::MAX_BLOCK_BITS_DEF,
  parameter int COUNT_WIDTH    = bth_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bth_pkg::mem_req_t                 req,
  input  logic [2*MAX_BLOCK_BITS-1:0]       req_addr,
  output logic                              accept_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bth_pkg::COUNT_FIELD_W-1:0] out_count,
  output logic                              out_is_saturated
);
  import bth_pkg::*;

  localparam int AW        = 2 * MAX_BLOCK_BITS;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];

  logic                   clr_busy_r;
  logic [AW-1:0]          clr_addr_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;

  logic                   s1_valid_r;
  logic                   s1_read_r;
  logic [AW-1:0]          s1_addr_r;
  logic                   wb_valid_r;
  logic [AW-1:0]          wb_addr_r;
  logic [COUNT_WIDTH-1:0] wb_data_r;

  logic                   out_valid_r;
  logic [COUNT_FIELD_W-1:0] out_count_r;
  logic                   out_sat_r;

  logic                   s1_go;
  logic                   s1_wr;
  logic [COUNT_WIDTH-1:0] s1_data;
  logic [COUNT_WIDTH-1:0] s1_inc;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;

  // stage 1 moves on unless a read result has nowhere to go
  assign s1_go     = !s1_read_r || !out_valid_r || out_ready;
  assign s1_wr     = s1_valid_r && !s1_read_r;
  assign accept_ok = !clr_busy_r && (!s1_valid_r || s1_go);

  // last write wins over the value read in the same edge
  assign s1_data = (wb_valid_r && (wb_addr_r == s1_addr_r)) ? wb_data_r : rd_data_r;
  assign s1_inc  = (s1_data == COUNT_MAX) ? s1_data : s1_data + COUNT_WIDTH'(1);

  // write port shared by the clearing pass and the increment stage
  assign mem_we = clr_busy_r || s1_wr;
  assign mem_wa = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign mem_wd = clr_busy_r ? '0 : s1_inc;

  // counter memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (req.valid) begin
      rd_data_r <= mem[req_addr];
    end
  end

  // clearing pass after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_read_r  <= 1'b0;
    end else if (!s1_valid_r || s1_go) begin
      s1_valid_r <= req.valid;
      s1_read_r  <= req.is_read;
    end
  end

  // stage 1 address, loaded with each new request
  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_addr_r <= req_addr;
    end
  end

  // forwarding register holds the most recent increment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (s1_wr) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= s1_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_read_r && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_read_r && s1_go) begin
      out_count_r <= COUNT_FIELD_W'(s1_data);
      out_sat_r   <= (s1_data == COUNT_MAX);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count        = out_count_r;
  assign out_is_saturated = out_sat_r;

  // no store traffic while the clearing pass runs
  a_idle_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !req.valid))
    else $error("store access during clearing pass");

  // a request only enters when stage 1 can take it
  a_req_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (!s1_valid_r || s1_go))
    else $error("request issued into a stalled stage");

  // a stalled read keeps its place and address
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && s1_read_r && $stable(s1_addr_r)))
    else $error("stalled read lost");

endmodule

// File: rtl/block_transition_histogram_core.sv
// top level of the block transition histogram
// depends on bth_pkg, bth_in_if, bth_out_if, bth_assembler, bth_count_mem
`timescale 1ns / 1ps
//
//  channel   dir  handshake          beat contents
//  in_ch     in   valid/ready        func, cell_bit, from_block, to_block
//  out_ch    out  valid/ready        count, is_saturated (one per read)
//  cfg_*     in   cfg_wr_en only     cfg_wr_data = block_size
//
//  one input beat per cycle when ready; a read passes stage 1, then the result register
//  each completed block but the first since reset or a size write costs one read-modify-write
//  after reset a clearing pass zeroes all 2^(2*MAX_BLOCK_BITS) store entries
//  (256 by default), in_ch.ready low throughout
//  in_ch.ready drops while a read waits behind a full, stalled result register

module block_transition_histogram_core #(
  parameter int MAX_BLOCK_BITS = bth_pkg::MAX_BLOCK_BITS_DEF,
  parameter int COUNT_WIDTH    = bth_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bth_pkg::SIZE_W-1:0] cfg_wr_data,
  bth_in_if.sink                     in_ch,
  bth_out_if.source                  out_ch
);
  import bth_pkg::*;

  mem_req_t                    req;
  logic [2*MAX_BLOCK_BITS-1:0] req_addr;
  logic                        accept_ok;
  logic                        accept;

  // input beat accepted
  assign in_ch.ready = accept_ok;
  assign accept      = in_ch.valid && accept_ok;

  bth_assembler #(
    .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
  ) u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .func        (in_ch.func),
    .cell_bit    (in_ch.cell_bit),
    .from_block  (in_ch.from_block),
    .to_block    (in_ch.to_block),
    .req         (req),
    .req_addr    (req_addr)
  );

  bth_count_mem #(
    .MAX_BLOCK_BITS (MAX_BLOCK_BITS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_mem (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .req_addr         (req_addr),
    .accept_ok        (accept_ok),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_count        (out_ch.count),
    .out_is_saturated (out_ch.is_saturated)
  );

endmodule

// File: test/tb_top.sv
// self-checking testbench for block_transition_histogram_core
// depends on bth_pkg, bth_in_if, bth_out_if and the core; drives both channels and the size port
`timescale 1ns / 1ps

module tb_top;
  import bth_pkg::*;

  localparam int BLOCK_BITS     = MAX_BLOCK_BITS_DEF;
  localparam int PAIR_COUNT     = 1 << (2 * BLOCK_BITS);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 232;
  localparam logic [COUNT_FIELD_W-1:0] COUNT_TOP = {COUNT_FIELD_W{1'b1}};

  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] count;
    logic                     is_saturated;
  } read_result_t;

  // shadow of the histogram: predicts every read and checks what comes back
  class transition_scoreboard;
    logic [SIZE_W-1:0]        size_reg;
    logic [BLOCK_BITS-1:0]    partial_bits;
    int                       partial_len;
    logic [BLOCK_BITS-1:0]    last_block;
    logic                     have_last;
    logic [COUNT_FIELD_W-1:0] pair_counts [PAIR_COUNT];
    read_result_t             expected_reads [$];
    int                       errors;

    function new();
      size_reg     = SIZE_RESET;
      partial_bits = '0;
      partial_len  = 0;
      last_block   = '0;
      have_last    = 1'b0;
      errors       = 0;
      foreach (pair_counts[i]) pair_counts[i] = '0;
    endfunction

    // size 0 acts as 1, anything above the maximum acts as the maximum
    function int block_span();
      if (size_reg == 0) return 1;
      if (size_reg > BLOCK_BITS) return BLOCK_BITS;
      return int'(size_reg);
    endfunction

    // a size write drops the partial block and forgets the last one
    function void set_block_size(logic [SIZE_W-1:0] v);
      size_reg     = v;
      partial_bits = '0;
      partial_len  = 0;
      have_last    = 1'b0;
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    function void note_beat(func_t f, logic b, logic [BLOCK_FIELD_W-1:0] from_b,
                            logic [BLOCK_FIELD_W-1:0] to_b);
      read_result_t r;
      logic [2*BLOCK_BITS-1:0] idx;
      if (f == FUNC_PUSH) begin
        partial_bits = {partial_bits[BLOCK_BITS-2:0], b};
        partial_len++;
        if (partial_len >= block_span()) begin
          // first block after reset or a size write only seeds the pair
          if (have_last) begin
            idx = {last_block, partial_bits};
            if (pair_counts[idx] != COUNT_TOP) pair_counts[idx]++;
          end
          last_block   = partial_bits;
          have_last    = 1'b1;
          partial_bits = '0;
          partial_len  = 0;
        end
      end else begin
        idx            = {from_b[BLOCK_BITS-1:0], to_b[BLOCK_BITS-1:0]};
        r.count        = pair_counts[idx];
        r.is_saturated = (pair_counts[idx] == COUNT_TOP);
        expected_reads.insert(expected_reads.size(), r);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [COUNT_FIELD_W-1:0] cnt, logic sat);
      read_result_t e;
      if (expected_reads.size() == 0) begin
        report($sformatf("unexpected result count=%0d sat=%0b", cnt, sat));
      end else begin
        e = expected_reads.pop_front();
        if (cnt !== e.count)
          report($sformatf("count got %0d exp %0d", cnt, e.count));
        if (sat !== e.is_saturated)
          report($sformatf("is_saturated got %0b exp %0b", sat, e.is_saturated));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;
  logic idle_en;
  int   quiet_cycles = 0;

  transition_scoreboard board = new();

  bth_in_if  in_ch ();
  bth_out_if out_ch ();

  block_transition_histogram_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: too long without any accepted beat ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: check accepted beats, stall at random
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_result(out_ch.count, out_ch.is_saturated);
      out_ch.ready <= idle_en ? ($urandom_range(99) >= 18) : 1'b1;
    end
  end

  // one input beat, with optional random gap in front
  task automatic send_beat(input func_t f, input logic b, input logic [BLOCK_FIELD_W-1:0] from_b,
                           input logic [BLOCK_FIELD_W-1:0] to_b);
    while (idle_en && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.cell_bit   <= b;
    in_ch.from_block <= from_b;
    in_ch.to_block   <= to_b;
    do @(posedge clk); while (!in_ch.ready);
    board.note_beat(f, b, from_b, to_b);
  endtask

  task automatic push_bit(input logic b);
    send_beat(FUNC_PUSH, b, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic read_pair(input logic [BLOCK_FIELD_W-1:0] from_b,
                           input logic [BLOCK_FIELD_W-1:0] to_b);
    send_beat(FUNC_READ, 1'($urandom_range(1)), from_b, to_b);
  endtask

  // stop sending, wait for all reads and for any trailing counter update
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [SIZE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.set_block_size(v);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly pushes; reads lean toward pairs reachable at the current size
  task automatic random_beat();
    int span_top;
    span_top = (1 << board.block_span()) - 1;
    if ($urandom_range(99) < 25) begin
      if ($urandom_range(1) == 1)
        read_pair(4'($urandom_range(span_top)), 4'($urandom_range(span_top)));
      else
        read_pair(4'($urandom_range(15)), 4'($urandom_range(15)));
    end else begin
      push_bit(1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_sizes [8];
    phase_sizes = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd3,
                    3'($urandom_range(7)), 3'($urandom_range(7))};
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    idle_en          = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_PUSH;
    in_ch.cell_bit   = 1'b0;
    in_ch.from_block = '0;
    in_ch.to_block   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, single-bit blocks, then four-bit blocks
    read_pair(4'd0, 4'd0);
    push_bit(1'b1);
    push_bit(1'b0);
    push_bit(1'b1);
    push_bit(1'b1);
    read_pair(4'd1, 4'd0);
    read_pair(4'd0, 4'd1);
    read_pair(4'd1, 4'd1);
    read_pair(4'd15, 4'd15);
    write_block_size(3'd4);
    repeat (4) push_bit(1'b1);
    repeat (4) push_bit(1'b0);
    read_pair(4'd15, 4'd0);
    read_pair(4'd0, 4'd15);
    // partial block thrown away by the size write
    push_bit(1'b1);
    push_bit(1'b0);
    write_block_size(3'd4);
    read_pair(4'd15, 4'd15);

    // random phases over several sizes, extremes included
    foreach (phase_sizes[p]) begin
      write_block_size(phase_sizes[p]);
      idle_en = (p != 5);
      repeat (PHASE_ITEMS) random_beat();
    end
    idle_en = 1'b1;

    drain();
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bth_pkg.sv
rtl/bth_in_if.sv
rtl/bth_out_if.sv
rtl/bth_assembler.sv
rtl/bth_count_mem.sv
rtl/block_transition_histogram_core.sv
test/tb_top.sv
